FILE: rtl/core/cme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cme_pkg;

	localparam int KIND_W = 3;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 7;
	localparam int ERR_W  = 3;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_START = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STEP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DATA  = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
	localparam logic [ERR_W-1:0] ERR_ADDR     = 3'd1;
	localparam logic [ERR_W-1:0] ERR_BLOCK    = 3'd2;
	localparam logic [ERR_W-1:0] ERR_NOT_NOW  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_MEM_FULL = 3'd4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_H     = 8'h48;

	localparam logic [WORD_W-1:0] SPACES = {4{CH_SPACE}};
	localparam logic [CNT_W-1:0]  DEC_RADIX = 7'd10;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_LR   = 3'd1,
		OP_SR   = 3'd2,
		OP_CR   = 3'd3,
		OP_BT   = 3'd4,
		OP_GD   = 3'd5,
		OP_PD   = 3'd6,
		OP_H    = 3'd7
	} op_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] word;
	} cmd_t;

	typedef struct packed {
		logic              is_print;
		logic [WORD_W-1:0] out_word;
		logic              last;
		logic              halted;
		logic              waiting_data;
		logic              toggle_out;
		logic [CNT_W-1:0]  counter_out;
		logic [ERR_W-1:0]  error;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/card_machine_executor.sv
`timescale 1ns / 1ps
`default_nettype none

// Card machine executor: a small teaching machine whose program and data share one
// single-port word memory with a registered read. One item is worked on at a time; the
// result register lets the next item be taken while a result still waits. Clear, load,
// start and data items go straight to the result; a step runs through fetch, decode and
// result, with one more memory read for the operand in LR and CR; PD does one read and
// one result per printed word. A result waits while the result output is stalled.
// A per-word valid flag makes unwritten words read as four spaces, so reset and clear
// job take effect at once with no clearing pass.
module card_machine_executor #(
	parameter int MEM_WORDS   = 100,
	parameter int BLOCK_WORDS = 10
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_stall,
	input  wire cme_pkg::cmd_t cmd_item,
	output logic               res_valid,
	input  wire                res_stall,
	output cme_pkg::res_t      res_item
);

	import cme_pkg::*;

	localparam int AW  = $clog2(MEM_WORDS);
	localparam int LPW = $clog2(MEM_WORDS + 1);
	localparam int BW  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DEC  = 6'b000010,
		S_OPR  = 6'b000100,
		S_EMIT = 6'b001000,
		S_PRD  = 6'b010000,
		S_PWR  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] valid_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rvld_q;

	logic [WORD_W-1:0] general_reg_q;
	logic              toggle_q;
	logic [AW-1:0]     ic_q;
	logic [LPW-1:0]    lp_q;
	logic              stopped_q;
	logic              gd_pending_q;
	logic [AW-1:0]     gd_addr_q;
	logic [BW-1:0]     gd_cnt_q;
	logic [AW-1:0]     pd_addr_q;
	logic [BW-1:0]     pd_k_q;
	op_t               op_q;
	logic [ERR_W-1:0]  err_q;

	res_t              res_q;
	logic              res_valid_q;

	logic              cmd_take;
	logic              res_free;
	logic              res_load;
	logic              load_ok;
	logic              step_ok;
	logic              pd_last;
	logic              clear_job;
	logic [WORD_W-1:0] rd_word;
	logic [AW-1:0]     ic_next;

	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata;

	logic [7:0]        c0, c1, c2, c3;
	logic [3:0]        d2, d3;
	logic [CNT_W-1:0]  addr_dec;
	logic [AW-1:0]     op_addr;
	op_t               op_raw;
	op_t               op_eff;
	logic [ERR_W-1:0]  err_dec;
	res_t              res_next;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign res_load  = ((state_q == S_EMIT) || (state_q == S_PWR)) && res_free;
	assign load_ok   = stopped_q && !gd_pending_q && (lp_q < LPW'(MEM_WORDS));
	assign step_ok   = !stopped_q && !gd_pending_q;
	assign pd_last   = (pd_k_q == BW'(BLOCK_WORDS - 1));
	assign clear_job = cmd_take && (cmd_item.kind == KIND_CLEAR);
	assign rd_word   = rvld_q ? rdata_q : SPACES;
	assign ic_next   = (ic_q == AW'(MEM_WORDS - 1)) ? '0 : ic_q + 1'b1;

	// decode the fetched instruction word
	always_comb begin
		c0 = rd_word[31:24];
		c1 = rd_word[23:16];
		c2 = rd_word[15:8];
		c3 = rd_word[7:0];
		d2 = 4'(c2 - CH_ZERO);
		d3 = 4'(c3 - CH_ZERO);
		addr_dec = 7'({3'b000, d2} * DEC_RADIX) + {3'b000, d3};
		op_addr = addr_dec[AW-1:0];
		if (c0 == CH_L && c1 == CH_R) begin
			op_raw = OP_LR;
		end else if (c0 == CH_S && c1 == CH_R) begin
			op_raw = OP_SR;
		end else if (c0 == CH_C && c1 == CH_R) begin
			op_raw = OP_CR;
		end else if (c0 == CH_B && c1 == CH_T) begin
			op_raw = OP_BT;
		end else if (c0 == CH_G && c1 == CH_D) begin
			op_raw = OP_GD;
		end else if (c0 == CH_P && c1 == CH_D) begin
			op_raw = OP_PD;
		end else if (c0 == CH_H) begin
			op_raw = OP_H;
		end else begin
			op_raw = OP_NONE;
		end
		err_dec = ERR_NONE;
		if (op_raw != OP_NONE && op_raw != OP_H) begin
			if (!(c2 inside {[CH_ZERO:CH_NINE]}) || !(c3 inside {[CH_ZERO:CH_NINE]})) begin
				err_dec = ERR_ADDR;
			end else if (addr_dec >= CNT_W'(MEM_WORDS)) begin
				err_dec = ERR_ADDR;
			end else if ((op_raw == OP_GD || op_raw == OP_PD) &&
				({1'b0, addr_dec} + 8'(BLOCK_WORDS) > 8'(MEM_WORDS))) begin
				err_dec = ERR_BLOCK;
			end
		end
		op_eff = (err_dec != ERR_NONE) ? OP_NONE : op_raw;
	end

	// single memory port
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = general_reg_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					case (cmd_item.kind)
						KIND_LOAD: begin
							mem_we    = load_ok;
							mem_addr  = lp_q[AW-1:0];
							mem_wdata = cmd_item.word;
						end
						KIND_DATA: begin
							mem_we    = gd_pending_q;
							mem_addr  = gd_addr_q + AW'(gd_cnt_q);
							mem_wdata = cmd_item.word;
						end
						KIND_STEP: begin
							mem_re   = step_ok;
							mem_addr = ic_q;
						end
						default: ;
					endcase
				end
			end
			S_DEC: begin
				mem_addr = op_addr;
				mem_we   = (op_eff == OP_SR);
				mem_re   = (op_eff == OP_LR) || (op_eff == OP_CR);
			end
			S_PRD: begin
				mem_re   = 1'b1;
				mem_addr = pd_addr_q + AW'(pd_k_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (mem_re) begin
				rvld_q <= valid_q[mem_addr];
			end
			if (clear_job) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[mem_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			general_reg_q <= '0;
			toggle_q      <= 1'b0;
			ic_q          <= '0;
			lp_q          <= '0;
			stopped_q     <= 1'b1;
			gd_pending_q  <= 1'b0;
			gd_addr_q     <= '0;
			gd_cnt_q      <= '0;
			pd_addr_q     <= '0;
			pd_k_q        <= '0;
			op_q          <= OP_NONE;
			err_q         <= ERR_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= S_EMIT;
						err_q   <= ERR_NONE;
						case (cmd_item.kind)
							KIND_CLEAR: begin
								lp_q         <= '0;
								toggle_q     <= 1'b0;
								stopped_q    <= 1'b1;
								gd_pending_q <= 1'b0;
								gd_cnt_q     <= '0;
							end
							KIND_LOAD: begin
								if (!stopped_q || gd_pending_q) begin
									err_q <= ERR_NOT_NOW;
								end else if (!load_ok) begin
									err_q <= ERR_MEM_FULL;
								end else begin
									lp_q <= lp_q + 1'b1;
								end
							end
							KIND_START: begin
								if (!stopped_q) begin
									err_q <= ERR_NOT_NOW;
								end else begin
									ic_q         <= '0;
									stopped_q    <= 1'b0;
									gd_pending_q <= 1'b0;
									gd_cnt_q     <= '0;
								end
							end
							KIND_STEP: begin
								if (step_ok) begin
									state_q <= S_DEC;
								end else begin
									err_q <= ERR_NOT_NOW;
								end
							end
							KIND_DATA: begin
								if (!gd_pending_q) begin
									err_q <= ERR_NOT_NOW;
								end else if (gd_cnt_q == BW'(BLOCK_WORDS - 1)) begin
									gd_pending_q <= 1'b0;
									gd_cnt_q     <= '0;
								end else begin
									gd_cnt_q <= gd_cnt_q + 1'b1;
								end
							end
							default: begin
								err_q <= ERR_NOT_NOW;
							end
						endcase
					end
				end
				S_DEC: begin
					ic_q    <= ic_next;
					err_q   <= err_dec;
					op_q    <= op_eff;
					state_q <= S_EMIT;
					case (op_eff)
						OP_LR, OP_CR: begin
							state_q <= S_OPR;
						end
						OP_BT: begin
							if (toggle_q) begin
								ic_q <= op_addr;
							end
						end
						OP_GD: begin
							gd_pending_q <= 1'b1;
							gd_addr_q    <= op_addr;
							gd_cnt_q     <= '0;
						end
						OP_PD: begin
							pd_addr_q <= op_addr;
							pd_k_q    <= '0;
							state_q   <= S_PRD;
						end
						OP_H: begin
							stopped_q <= 1'b1;
						end
						default: ;
					endcase
				end
				S_OPR: begin
					if (op_q == OP_LR) begin
						general_reg_q <= rd_word;
					end else begin
						toggle_q <= (general_reg_q == rd_word);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				S_PRD: begin
					state_q <= S_PWR;
				end
				S_PWR: begin
					if (res_free) begin
						if (pd_last) begin
							state_q <= S_IDLE;
						end else begin
							pd_k_q  <= pd_k_q + 1'b1;
							state_q <= S_PRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res_next.is_print     = (state_q == S_PWR);
		res_next.out_word     = (state_q == S_PWR) ? rd_word : '0;
		res_next.last         = (state_q == S_PWR) ? pd_last : 1'b1;
		res_next.halted       = stopped_q;
		res_next.waiting_data = gd_pending_q;
		res_next.toggle_out   = toggle_q;
		res_next.counter_out  = CNT_W'(ic_q);
		res_next.error        = err_q;
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

`ifndef ASSERT_OFF
	a_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("memory read and write in one cycle");

	a_pending_running: assert property (@(posedge clk) disable iff (!arst_n)
		gd_pending_q |-> !stopped_q)
		else $error("block read pending while stopped");

	a_print_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PWR) && res_free && pd_last |=> (state_q == S_IDLE) && res_valid_q
			&& res_q.last && res_q.is_print)
		else $error("print block did not close with a last item");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && (state_q == S_IDLE) |-> (mem_addr < AW'(MEM_WORDS)))
		else $error("memory write beyond last word");
`endif

endmodule

`default_nettype wire
